// ----- sv/bpru_pkg.sv -----
// Shared types and constants of the BMP pixel row unpacker.
// Used by every module of the block; has no dependencies of its own.
`default_nettype none

package bpru_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_FORMAT = 3'd0;
    localparam logic [2:0] CFG_WIDTH  = 3'd1;
    localparam logic [2:0] CFG_HEIGHT = 3'd2;
    localparam logic [2:0] CFG_USED   = 3'd3;
    localparam logic [2:0] CFG_RED    = 3'd4;
    localparam logic [2:0] CFG_GREEN  = 3'd5;
    localparam logic [2:0] CFG_BLUE   = 3'd6;
    localparam logic [2:0] CFG_ALPHA  = 3'd7;

    // Pixel format codes.
    localparam logic [2:0] FMT_1BPP  = 3'd0;
    localparam logic [2:0] FMT_4BPP  = 3'd1;
    localparam logic [2:0] FMT_8BPP  = 3'd2;
    localparam logic [2:0] FMT_16BPP = 3'd3;
    localparam logic [2:0] FMT_24BPP = 3'd4;
    localparam logic [2:0] FMT_32BPP = 3'd5;

    // Input action codes and result kinds.
    localparam logic ACT_PALETTE = 1'b0;
    localparam logic ACT_IMAGE   = 1'b1;
    localparam logic KIND_PIXEL  = 1'b0;
    localparam logic KIND_ERROR  = 1'b1;

    localparam int COL_W   = 14;  // job column, enough for any width up to 16384
    localparam int Q_DEPTH = 4;
    localparam int QAW     = 2;

    localparam logic [7:0] OPAQUE = 8'hff;

    typedef enum logic [2:0] {
        JOB_PAL,
        JOB_IDX1,
        JOB_IDX4,
        JOB_IDX8,
        JOB_RGBA,
        JOB_MASK
    } t_job_type;

    typedef struct packed {
        logic        action;
        logic [7:0]  palette_slot;
        logic [23:0] palette_rgb;
        logic [7:0]  image_byte;
    } t_pix_in;

    typedef struct packed {
        logic        kind;
        logic [31:0] rgba;
        logic [11:0] row;
        logic [11:0] column;
        logic        last_of_item;
        logic        image_done;
    } t_pix_out;

    // Configuration write as seen by the front and the back.
    typedef struct packed {
        logic        valid;
        logic [2:0]  index;
        logic [31:0] data;
    } t_cfg_wr;

    // Work handed from the front to the back; data holds the byte, a color word,
    // a finished pixel or a palette slot and color.
    typedef struct packed {
        t_job_type        jtype;
        logic [3:0]       count;
        logic             err;
        logic             done;
        logic [11:0]      row;
        logic [COL_W-1:0] col;
        logic [31:0]      data;
    } t_job;

endpackage

`default_nettype wire

// ----- sv/bpru_front.sv -----
// Front end: geometry registers, image position counters and byte classification.
// Depends on bpru_pkg; feeds jobs into bpru_queue.
`default_nettype none

module bpru_front import bpru_pkg::*; #(
    parameter int MAX_WIDTH     = 4096,
    parameter int PALETTE_DEPTH = 256
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_cfg_wr i_cfg,
    input  wire logic    i_accept,
    input  wire t_pix_in i_item,
    output logic         o_push,
    output t_job         o_job
);

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int BW = $clog2(MAX_WIDTH) + 4;

    logic [2:0]    r_fmt;
    logic [12:0]   r_width;
    logic [13:0]   r_height;
    logic [8:0]    r_used;
    logic          r_pend;
    logic          r_stop;
    logic [11:0]   r_row;
    logic [CW-1:0] r_col;
    logic [BW-1:0] r_rbc;
    logic [23:0]   r_part;
    logic [1:0]    r_phase;

    logic [11:0]   n_row;
    logic [CW-1:0] n_col;
    logic [BW-1:0] n_rbc;
    logic [23:0]   n_part;
    logic [1:0]    n_phase;
    logic          n_stop;

    logic [14:0]   w_ext;
    logic [CW-1:0] w;
    logic [BW-1:0] w_b;
    logic [BW-1:0] data_bytes;
    logic [BW-1:0] row_bytes;
    logic [13:0]   mag;
    logic          up;
    logic [11:0]   first_row;
    logic [11:0]   last_row;
    logic [8:0]    lim;

    logic [11:0]   s_row;
    logic [CW-1:0] s_col;
    logic [BW-1:0] s_rbc;
    logic [23:0]   s_part;
    logic [1:0]    s_phase;

    logic [CW-1:0] avail;
    logic          col_ok;
    logic [7:0]    b;
    logic [1:0]    need;
    t_job          job;
    logic          emit;

    // Effective width, clamped to one through MAX_WIDTH.
    always_comb begin
        w_ext = {2'b00, r_width};
        if (w_ext == 15'd0) begin
            w_ext = 15'd1;
        end else if (w_ext > 15'(MAX_WIDTH)) begin
            w_ext = 15'(MAX_WIDTH);
        end
        w   = CW'(w_ext);
        w_b = BW'(w);
    end

    // Data bytes per row for each format, and the row length padded to four bytes.
    always_comb begin
        unique case (r_fmt)
            FMT_1BPP:  data_bytes = (w_b + BW'(7)) >> 3;
            FMT_4BPP:  data_bytes = (w_b + BW'(1)) >> 1;
            FMT_16BPP: data_bytes = w_b << 1;
            FMT_24BPP: data_bytes = w_b + (w_b << 1);
            FMT_32BPP: data_bytes = w_b << 2;
            default:   data_bytes = w_b;
        endcase
        row_bytes = (data_bytes + BW'(3)) & ~BW'(3);
    end

    // Row count and direction from the signed height.
    always_comb begin
        up  = ~r_height[13];
        mag = r_height[13] ? (14'd0 - r_height) : r_height;
        if (mag == 14'd0) begin
            mag = 14'd1;
            up  = 1'b1;
        end else if (mag > 14'd4096) begin
            mag = 14'd4096;
        end
        first_row = up ? 12'(mag - 14'd1) : 12'd0;
        last_row  = up ? 12'd0 : 12'(mag - 14'd1);
        lim       = (r_used < 9'(PALETTE_DEPTH)) ? r_used : 9'(PALETTE_DEPTH);
    end

    // A geometry write restarts the position before the next byte is seen.
    always_comb begin
        s_row   = r_pend ? first_row : r_row;
        s_col   = r_pend ? '0 : r_col;
        s_rbc   = r_pend ? '0 : r_rbc;
        s_part  = r_pend ? '0 : r_part;
        s_phase = r_pend ? 2'd0 : r_phase;
    end

    // Classify one image byte into a job and the next position.
    always_comb begin
        b       = i_item.image_byte;
        avail   = w - s_col;
        col_ok  = s_col < w;
        need    = (r_fmt == FMT_16BPP) ? 2'd1 : ((r_fmt == FMT_24BPP) ? 2'd2 : 2'd3);
        job     = '0;
        job.row = s_row;
        job.col = COL_W'(s_col);
        emit    = 1'b0;
        n_row   = s_row;
        n_col   = s_col;
        n_rbc   = s_rbc;
        n_part  = s_part;
        n_phase = s_phase;
        n_stop  = r_stop;

        if (i_item.action == ACT_PALETTE) begin
            job.jtype = JOB_PAL;
            job.count = 4'd1;
            job.data  = {i_item.palette_slot, i_item.palette_rgb};
            emit      = 1'b1;
        end else if (!r_stop && r_fmt <= FMT_32BPP) begin
            job.data = {24'd0, b};
            if (s_rbc < data_bytes) begin
                unique case (r_fmt)
                    FMT_1BPP: begin
                        job.jtype = JOB_IDX1;
                        if (BW'(avail) >= BW'(8)) begin
                            job.count = 4'd8;
                        end else begin
                            job.count = 4'(BW'(avail));
                        end
                    end
                    FMT_4BPP: begin
                        job.jtype = JOB_IDX4;
                        if (col_ok) begin
                            if ({5'd0, b[7:4]} >= lim) begin
                                job.count = 4'd1;
                                job.err   = 1'b1;
                            end else if (BW'(s_col) + BW'(1) < w_b) begin
                                job.count = 4'd2;
                                job.err   = {5'd0, b[3:0]} >= lim;
                            end else begin
                                job.count = 4'd1;
                            end
                        end
                    end
                    FMT_8BPP: begin
                        job.jtype = JOB_IDX8;
                        job.count = {3'd0, col_ok};
                        job.err   = col_ok && ({1'b0, b} >= lim);
                    end
                    FMT_24BPP: begin
                        job.jtype = JOB_RGBA;
                        if (s_phase < need) begin
                            n_part  = s_part | (24'(b) << {s_phase, 3'b000});
                            n_phase = s_phase + 2'd1;
                        end else begin
                            job.count = {3'd0, col_ok};
                            job.data  = {OPAQUE, s_part[7:0], s_part[15:8], b};
                            n_part    = '0;
                            n_phase   = 2'd0;
                        end
                    end
                    default: begin
                        job.jtype = JOB_MASK;
                        if (s_phase < need) begin
                            n_part  = s_part | (24'(b) << {s_phase, 3'b000});
                            n_phase = s_phase + 2'd1;
                        end else begin
                            job.count = {3'd0, col_ok};
                            job.data  = {8'd0, s_part} | (32'(b) << {s_phase, 3'b000});
                            n_part    = '0;
                            n_phase   = 2'd0;
                        end
                    end
                endcase
            end

            emit     = job.count != 4'd0;
            job.done = !job.err && (s_row == last_row)
                       && (BW'(s_col) + BW'(job.count) == w_b);

            if (job.err) begin
                n_stop = 1'b1;
            end else begin
                n_col = CW'(BW'(s_col) + BW'(job.count));
                n_rbc = s_rbc + BW'(1);
                if (n_rbc >= row_bytes) begin
                    if (s_row == last_row) begin
                        n_row = first_row;
                    end else if (up) begin
                        n_row = s_row - 12'd1;
                    end else begin
                        n_row = s_row + 12'd1;
                    end
                    n_col   = '0;
                    n_rbc   = '0;
                    n_part  = '0;
                    n_phase = 2'd0;
                end
            end
        end
    end

    assign o_push = i_accept && emit;
    assign o_job  = job;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt    <= FMT_8BPP;
            r_width  <= 13'd1;
            r_height <= 14'd1;
            r_used   <= 9'd256;
            r_pend   <= 1'b1;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_FORMAT: r_fmt    <= i_cfg.data[2:0];
                    CFG_WIDTH:  r_width  <= i_cfg.data[12:0];
                    CFG_HEIGHT: r_height <= i_cfg.data[13:0];
                    CFG_USED:   r_used   <= i_cfg.data[8:0];
                    default: ;
                endcase
            end
            if (i_cfg.valid && (i_cfg.index == CFG_FORMAT || i_cfg.index == CFG_WIDTH
                                || i_cfg.index == CFG_HEIGHT)) begin
                r_pend <= 1'b1;
            end else if (i_accept) begin
                r_pend <= 1'b0;
            end
        end
    end

    // Position state advances with each accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop  <= 1'b0;
            r_row   <= '0;
            r_col   <= '0;
            r_rbc   <= '0;
            r_part  <= '0;
            r_phase <= 2'd0;
        end else if (i_accept) begin
            r_stop  <= n_stop;
            r_row   <= n_row;
            r_col   <= n_col;
            r_rbc   <= n_rbc;
            r_part  <= n_part;
            r_phase <= n_phase;
        end
    end

endmodule

`default_nettype wire

// ----- sv/bpru_queue.sv -----
// Short job queue between the front and the back of the pixel unpacker.
// Depends on bpru_pkg for the job type and the depth.
`default_nettype none

module bpru_queue import bpru_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_valid,
    output t_job      o_head
);

    t_job           r_mem [Q_DEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QAW:0]   r_cnt;

    assign o_full  = r_cnt == (QAW + 1)'(Q_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_head  = r_mem[r_rp];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QAW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QAW'(1);
            end
            r_cnt <= r_cnt + (QAW + 1)'(i_push) - (QAW + 1)'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("job pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("job popped from an empty queue");

endmodule

`default_nettype wire

// ----- sv/bpru_back.sv -----
// Back end: palette memory, field mask extraction and one-pixel-per-cycle output
// while the output is not stalled. Depends on bpru_pkg; takes jobs from bpru_queue.
`default_nettype none

module bpru_back import bpru_pkg::*; #(
    parameter int PALETTE_DEPTH = 256
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_cfg_wr i_cfg,
    input  wire logic    i_head_valid,
    input  wire t_job    i_head,
    output logic         o_pop,
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    output t_pix_out     o_out_data
);

    localparam int AW = $clog2(PALETTE_DEPTH);

    // Per-mask values derived from the mask registers and registered.
    typedef struct packed {
        logic        zero;
        logic        wide;
        logic [4:0]  drop;
        logic [3:0]  up;
        logic [31:0] ones;
    } t_field;

    typedef struct packed {
        logic        kind;
        logic        use_pal;
        logic [31:0] rgba;
        logic [11:0] row;
        logic [11:0] column;
        logic        last;
        logic        done;
    } t_stage;

    logic [23:0] r_pal [PALETTE_DEPTH];
    logic [23:0] r_pal_q;
    logic [31:0] r_mask [4];
    t_field      r_fld [4];
    logic [2:0]  r_k;
    logic        r_av;
    t_stage      r_a;
    logic        r_bv;
    t_pix_out    r_b;

    logic        b_free;
    logic        a_free;
    logic        a_load;
    logic        pal_wr;
    logic        k_last;
    logic [7:0]  idx;
    t_stage      n_a;
    t_pix_out    n_b;
    logic [31:0] masked;

    function automatic t_field f_derive(input logic [31:0] mask);
        t_field     f;
        logic [5:0] pop;
        logic [4:0] lo;
        logic       seen;
        pop  = '0;
        lo   = '0;
        seen = 1'b0;
        for (int i = 0; i < 32; i++) begin
            pop = pop + 6'(mask[i]);
            if (mask[i] && !seen) begin
                lo   = 5'(i);
                seen = 1'b1;
            end
        end
        f.zero = mask == '0;
        f.wide = pop >= 6'd8;
        f.drop = (pop > 6'd8) ? 5'(6'(lo) + pop - 6'd8) : lo;
        f.up   = 4'(6'd8 - pop);
        f.ones = (32'd1 << pop) - 32'd1;
        return f;
    endfunction

    function automatic logic [7:0] f_field(input logic [31:0] color,
                                           input logic [31:0] mask,
                                           input t_field f);
        logic [31:0] c;
        logic [7:0]  v;
        c = (color & mask) >> f.drop;
        if (f.zero) begin
            v = 8'd0;
        end else if (f.wide) begin
            v = c[7:0];
        end else if (c == f.ones) begin
            v = 8'hff;
        end else begin
            v = c[7:0] << f.up;
        end
        return v;
    endfunction

    // Mask registers and their derived shift and scale values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask[0] <= 32'h00ff0000;
            r_mask[1] <= 32'h0000ff00;
            r_mask[2] <= 32'h000000ff;
            r_mask[3] <= 32'hff000000;
        end else if (i_cfg.valid && i_cfg.index >= CFG_RED) begin
            r_mask[i_cfg.index[1:0]] <= i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r_fld[i] <= f_derive(r_mask[i]);
        end
    end

    // Handshake between the two output stages and the sequencer.
    assign b_free = !r_bv || !i_out_stall;
    assign a_free = !r_av || b_free;
    assign k_last = {1'b0, r_k} == (i_head.count - 4'd1);
    assign pal_wr = i_head_valid && i_head.jtype == JOB_PAL;
    assign a_load = i_head_valid && i_head.jtype != JOB_PAL && a_free;
    assign o_pop  = pal_wr || (a_load && k_last);

    // Palette index for the current pixel of the head job.
    always_comb begin
        unique case (i_head.jtype)
            JOB_IDX1: idx = {7'd0, i_head.data[3'd7 - r_k]};
            JOB_IDX4: idx = (r_k == 3'd0) ? {4'd0, i_head.data[7:4]}
                                          : {4'd0, i_head.data[3:0]};
            default:  idx = i_head.data[7:0];
        endcase
    end

    // First stage: pick the pixel, convert direct colors, start the palette read.
    always_comb begin
        masked = {f_field(i_head.data, r_mask[3], r_fld[3]),
                  f_field(i_head.data, r_mask[2], r_fld[2]),
                  f_field(i_head.data, r_mask[1], r_fld[1]),
                  f_field(i_head.data, r_mask[0], r_fld[0])};
        if (r_fld[3].zero) begin
            masked[31:24] = OPAQUE;
        end
        n_a.last    = k_last;
        n_a.kind    = (i_head.err && k_last) ? KIND_ERROR : KIND_PIXEL;
        n_a.done    = i_head.done && k_last;
        n_a.row     = i_head.row;
        n_a.column  = 12'(i_head.col + COL_W'(r_k));
        n_a.use_pal = i_head.jtype == JOB_IDX1 || i_head.jtype == JOB_IDX4
                      || i_head.jtype == JOB_IDX8;
        n_a.rgba    = (i_head.jtype == JOB_MASK) ? masked : i_head.data;
    end

    // Second stage: the output register.
    always_comb begin
        n_b.kind         = r_a.kind;
        n_b.row          = r_a.row;
        n_b.column       = r_a.column;
        n_b.last_of_item = r_a.last;
        n_b.image_done   = r_a.done;
        if (r_a.kind == KIND_ERROR) begin
            n_b.rgba = '0;
        end else if (r_a.use_pal) begin
            n_b.rgba = {OPAQUE, r_pal_q};
        end else begin
            n_b.rgba = r_a.rgba;
        end
    end

    // Palette memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (pal_wr && {1'b0, i_head.data[31:24]} < 9'(PALETTE_DEPTH)) begin
            r_pal[AW'(i_head.data[31:24])] <= i_head.data[23:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_load) begin
            r_pal_q <= r_pal[AW'(idx)];
        end
    end

    // Pipeline control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k  <= 3'd0;
            r_av <= 1'b0;
            r_bv <= 1'b0;
        end else begin
            if (a_load) begin
                r_k <= k_last ? 3'd0 : r_k + 3'd1;
            end
            if (a_free) begin
                r_av <= a_load;
            end
            if (b_free) begin
                r_bv <= r_av;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_load) begin
            r_a <= n_a;
        end
        if (b_free && r_av) begin
            r_b <= n_b;
        end
    end

    assign o_out_valid = r_bv;
    assign o_out_data  = r_b;

    a_k_in_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_head_valid && i_head.jtype != JOB_PAL) |-> ({1'b0, r_k} < i_head.count))
        else $error("pixel counter ran past the head job");

    a_k_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_head_valid |-> r_k == 3'd0)
        else $error("pixel counter not cleared between jobs");

endmodule

`default_nettype wire

// ----- sv/bmp_pixel_row_unpacker.sv -----
// BMP pixel row unpacker: accepts one byte or palette write per cycle while o_in_stall is low,
// emits one pixel per cycle while i_out_stall is low. A byte passes through the job queue, the
// first stage and output register. Throughput: one byte per cycle at 8 bpp and wider; the port
// takes up to 2 pixels per 4 bpp byte, 8 per 1 bpp byte. A four-job queue decouples the two ends.
// Reset (synchronous, active low) restores register defaults and the first row;
// the palette holds no reset value and must be written before it is used.
`default_nettype none

module bmp_pixel_row_unpacker import bpru_pkg::*; #(
    parameter int MAX_WIDTH     = 4096,
    parameter int PALETTE_DEPTH = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_pix_in     i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_pix_out         o_out_data,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    t_cfg_wr cfg;
    logic    accept;
    logic    push;
    logic    pop;
    logic    q_full;
    logic    q_valid;
    t_job    job;
    t_job    head;

    // Configuration transactions are always taken.
    assign o_cfg_ready = 1'b1;
    assign cfg         = '{valid: i_cfg_valid, index: i_cfg_index, data: i_cfg_data};
    assign o_in_stall  = q_full;
    assign accept      = i_in_valid && !q_full;

    bpru_front #(
        .MAX_WIDTH     (MAX_WIDTH),
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_accept (accept),
        .i_item   (i_in_data),
        .o_push   (push),
        .o_job    (job)
    );

    bpru_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (head)
    );

    bpru_back #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_head_valid (q_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_data   (o_out_data)
    );

endmodule

`default_nettype wire
